// ===== hdl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// Pure pursuit steering package
// Shared types, angle constants and controller/datapath command structs.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int PI_Q         = 25736;
    localparam int HALF_PI_Q    = 12868;
    localparam int TWO_PI_Q     = 51472;
    localparam int CORDIC_STEPS = 14;
    localparam int INV_GAIN_Q14 = 9949;

    // Output status codes
    localparam logic [2:0] ST_DRIVE    = 3'd0;
    localparam logic [2:0] ST_OBSTACLE = 3'd1;
    localparam logic [2:0] ST_HALTED   = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_LOADED   = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_SPEED = 3'd0;
    localparam logic [2:0] REG_LOOK  = 3'd1;
    localparam logic [2:0] REG_TRACK = 3'd2;
    localparam logic [2:0] REG_GOAL  = 3'd3;
    localparam logic [2:0] REG_LEN   = 3'd4;

    // Datapath operations requested by the controller
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LATCH   = 4'd1;  // not issued by the controller; the datapath takes no action on it
    localparam logic [3:0] OP_READ    = 4'd2;  // store read issued
    localparam logic [3:0] OP_DIST    = 4'd3;  // dx, dy from read data
    localparam logic [3:0] OP_SQUARE  = 4'd4;  // squares
    localparam logic [3:0] OP_SUM     = 4'd5;  // d2 = sum
    localparam logic [3:0] OP_VEC_INI = 4'd6;  // vectoring prerotation
    localparam logic [3:0] OP_VEC_IT  = 4'd7;  // one vectoring step
    localparam logic [3:0] OP_ROT_INI = 4'd8;  // wrap and fold
    localparam logic [3:0] OP_ROT_IT  = 4'd9;  // one rotation step
    localparam logic [3:0] OP_MUL1    = 4'd10; // track * speed
    localparam logic [3:0] OP_MUL2    = 4'd11; // * sine
    localparam logic [3:0] OP_DIV_INI = 4'd12;
    localparam logic [3:0] OP_DIV_IT  = 4'd13;
    localparam logic [3:0] OP_SPEEDS  = 4'd14;

    typedef struct packed {
        logic [3:0]  op;
        logic [15:0] rd_index;  // store read address, 16 bits wide
        logic [3:0]  step;
    } pps_cmd_t;

    typedef struct packed {
        logic        far_enough;   // d2 >= lookahead^2
        logic        in_goal;      // d2 < tolerance^2
        logic        zero_vec;     // dx == dy == 0
    } pps_stat_t;

    function automatic logic [15:0] atan_q13(input logic [3:0] i);
        logic [15:0] r;
        begin
            unique case (i)
                4'd0:    r = 16'd6434;
                4'd1:    r = 16'd3798;
                4'd2:    r = 16'd2007;
                4'd3:    r = 16'd1019;
                4'd4:    r = 16'd511;
                4'd5:    r = 16'd256;
                4'd6:    r = 16'd128;
                4'd7:    r = 16'd64;
                4'd8:    r = 16'd32;
                4'd9:    r = 16'd16;
                4'd10:   r = 16'd8;
                4'd11:   r = 16'd4;
                4'd12:   r = 16'd2;
                4'd13:   r = 16'd1;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hdl/pps_datapath.sv =====
// ----------------------------------------------------------------------------
// Pure pursuit datapath
// Path store, distance squares, shared CORDIC unit, multiplier and divider.
// ----------------------------------------------------------------------------
module pps_datapath
    import pps_pkg::*;
#(
    parameter int PATH_DEPTH = 1024,
    parameter int AW         = 10
)
(
    input  logic               clk,
    input  pps_cmd_t           cmd,
    output pps_stat_t          stat,
    // store write
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic signed [15:0] wr_x,
    input  logic signed [15:0] wr_y,
    // pose and registers
    input  logic signed [15:0] pose_x,
    input  logic signed [15:0] pose_y,
    input  logic signed [15:0] pose_th,
    input  logic [10:0]        forward_speed,
    input  logic [10:0]        lookahead,
    input  logic [9:0]         track_width,
    input  logic [10:0]        goal_tolerance,
    output logic signed [15:0] left_speed,
    output logic signed [15:0] right_speed
);

    // Path memories
    logic signed [15:0] mem_x [PATH_DEPTH];
    logic signed [15:0] mem_y [PATH_DEPTH];
    logic signed [15:0] rd_x_reg, rd_y_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        rd_x_reg <= mem_x[cmd.rd_index[AW-1:0]];
        rd_y_reg <= mem_y[cmd.rd_index[AW-1:0]];
    end

    logic signed [16:0] dx_reg, dy_reg;
    logic [33:0]        sqx_reg, sqy_reg;
    logic [34:0]        d2_reg;
    logic signed [23:0] cx_reg, cy_reg;   // CORDIC x/y
    logic signed [17:0] cz_reg;           // CORDIC angle
    logic [20:0]        ts_reg;           // track * speed
    logic signed [36:0] num_reg;
    logic [35:0]        rem_reg;
    logic [35:0]        quo_reg;
    logic               neg_reg;
    logic signed [15:0] left_reg, right_reg;

    logic [21:0] l2, g2;
    assign l2 = 22'(lookahead) * 22'(lookahead);
    assign g2 = 22'(goal_tolerance) * 22'(goal_tolerance);

    assign stat.far_enough = d2_reg >= 35'(l2);
    assign stat.in_goal    = d2_reg < 35'(g2);
    assign stat.zero_vec   = (dx_reg == 17'sd0) && (dy_reg == 17'sd0);

    // shared CORDIC step terms
    logic signed [23:0] sh_x, sh_y;
    logic signed [17:0] at;
    assign sh_x = cx_reg >>> cmd.step;
    assign sh_y = cy_reg >>> cmd.step;
    assign at   = 18'(atan_q13(cmd.step));

    logic signed [18:0] alpha;
    logic signed [18:0] aw;
    logic [26:0]        den;
    logic [36:0]        mag;
    logic [36:0]        trial;
    logic signed [22:0] delta;
    logic signed [23:0] lsum, rsum;
    logic signed [23:0] ysat;

    always_comb
    begin
        // zero vector keeps angle 0 before subtracting heading
        alpha = (stat.zero_vec ? 19'sd0 : 19'(cz_reg)) - 19'(pose_th);
        aw = alpha;
        if (aw > 19'sd25736)       aw = aw - 19'sd51472;
        if (aw < -19'sd25736)      aw = aw + 19'sd51472;
        if (aw > 19'sd25736)       aw = aw - 19'sd51472;
        if (aw < -19'sd25736)      aw = aw + 19'sd51472;
        if (aw > 19'sd12868)       aw = 19'sd25736 - aw;
        else if (aw < -19'sd12868) aw = -19'sd25736 - aw;
        den   = (lookahead == 11'd0) ? 27'd16384 : {2'b0, lookahead, 14'b0};
        mag   = num_reg[36] ? 37'(-num_reg) : 37'(num_reg);
        trial = {rem_reg, quo_reg[35]} - 37'(den);
        delta = neg_reg ? -23'(quo_reg) : 23'(quo_reg);
        lsum  = 24'(signed'({8'b0, forward_speed})) - 24'(delta);
        rsum  = 24'(signed'({8'b0, forward_speed})) + 24'(delta);
        ysat  = cy_reg;
        if (ysat > 24'sd16384)  ysat = 24'sd16384;
        if (ysat < -24'sd16384) ysat = -24'sd16384;
    end

    // Sequence the arithmetic under controller command
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_DIST:
            begin
                dx_reg <= 17'(rd_x_reg) - 17'(pose_x);
                dy_reg <= 17'(rd_y_reg) - 17'(pose_y);
            end
            OP_SQUARE:
            begin
                sqx_reg <= 34'(dx_reg * dx_reg);
                sqy_reg <= 34'(dy_reg * dy_reg);
            end
            OP_SUM: d2_reg <= 35'(sqx_reg) + 35'(sqy_reg);
            OP_VEC_INI:
            begin
                if (dx_reg < 0)
                begin
                    if (dy_reg >= 0)
                    begin
                        cx_reg <= 24'(dy_reg) <<< 4;
                        cy_reg <= -(24'(dx_reg) <<< 4);
                        cz_reg <= 18'sd12868;
                    end
                    else
                    begin
                        cx_reg <= -(24'(dy_reg) <<< 4);
                        cy_reg <= 24'(dx_reg) <<< 4;
                        cz_reg <= -18'sd12868;
                    end
                end
                else
                begin
                    cx_reg <= 24'(dx_reg) <<< 4;
                    cy_reg <= 24'(dy_reg) <<< 4;
                    cz_reg <= 18'sd0;
                end
            end
            OP_VEC_IT:
            begin
                if (cy_reg >= 0)
                begin
                    cx_reg <= cx_reg + sh_y;
                    cy_reg <= cy_reg - sh_x;
                    cz_reg <= cz_reg + at;
                end
                else
                begin
                    cx_reg <= cx_reg - sh_y;
                    cy_reg <= cy_reg + sh_x;
                    cz_reg <= cz_reg - at;
                end
            end
            OP_ROT_INI:
            begin
                cx_reg <= 24'sd9949;
                cy_reg <= 24'sd0;
                cz_reg <= 18'(aw);
            end
            OP_ROT_IT:
            begin
                if (cz_reg >= 0)
                begin
                    cx_reg <= cx_reg - sh_y;
                    cy_reg <= cy_reg + sh_x;
                    cz_reg <= cz_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + sh_y;
                    cy_reg <= cy_reg - sh_x;
                    cz_reg <= cz_reg + at;
                end
            end
            OP_MUL1: ts_reg <= 21'(track_width) * 21'(forward_speed);
            OP_MUL2: num_reg <= 37'(signed'({1'b0, ts_reg})) * 37'(ysat);
            OP_DIV_INI:
            begin
                neg_reg <= num_reg[36];
                quo_reg <= 36'(mag + 37'(den >> 1));
                rem_reg <= 36'd0;
            end
            OP_DIV_IT:
            begin
                // one restoring division bit per cycle
                if (!trial[36])
                begin
                    rem_reg <= trial[35:0];
                    quo_reg <= {quo_reg[34:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[34:0], quo_reg[35]};
                    quo_reg <= {quo_reg[34:0], 1'b0};
                end
            end
            OP_SPEEDS:
            begin
                left_reg  <= (lsum > 24'sd32767) ? 16'sd32767 :
                             (lsum < -24'sd32768) ? -16'sd32768 : 16'(lsum);
                right_reg <= (rsum > 24'sd32767) ? 16'sd32767 :
                             (rsum < -24'sd32768) ? -16'sd32768 : 16'(rsum);
            end
            default: ;
        endcase
    end

    assign left_speed  = left_reg;
    assign right_speed = right_reg;

endmodule

// ===== hdl/pps_ctrl.sv =====
// ----------------------------------------------------------------------------
// Pure pursuit controller
// Sequences the search, CORDIC, multiply and divide steps for each driving tick.
// ----------------------------------------------------------------------------
module pps_ctrl
    import pps_pkg::*;
#(
    parameter int PATH_DEPTH = 1024,
    parameter int IW         = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        is_load,
    input  logic        obstacle,
    input  logic [10:0] path_length,
    input  pps_stat_t   stat,
    output pps_cmd_t    cmd,
    output logic        done,
    output logic        use_dp_speeds,
    output logic [2:0]  status,
    output logic [9:0]  target_index
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_RDWT  = 4'd2;
    localparam logic [3:0] S_DIST  = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_TEST  = 4'd6;
    localparam logic [3:0] S_VINI  = 4'd7;
    localparam logic [3:0] S_VIT   = 4'd8;
    localparam logic [3:0] S_RINI  = 4'd9;
    localparam logic [3:0] S_RIT   = 4'd10;
    localparam logic [3:0] S_MUL   = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;
    localparam logic [3:0] S_SPD   = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    // phase within the shared search/target/goal sequence
    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_TARGET = 2'd1;
    localparam logic [1:0] PH_GOAL   = 2'd2;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] start_reg, start_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          halted_reg, halted_next;
    logic [2:0]    status_reg, status_next;
    logic          dps_reg, dps_next;

    logic [IW-1:0] len;
    assign len = (32'(path_length) > PATH_DEPTH) ? IW'(PATH_DEPTH) : IW'(path_length);

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        start_next  = start_reg;
        cnt_next    = cnt_reg;
        halted_next = halted_reg;
        status_next = status_reg;
        dps_next    = dps_reg;
        cmd.op       = OP_NONE;
        cmd.rd_index = 16'(idx_reg);
        cmd.step     = cnt_reg[3:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    dps_next = 1'b0;
                    priority if (is_load)
                    begin
                        status_next = ST_LOADED;
                        state_next  = S_DONE;
                    end
                    else if (halted_reg)
                    begin
                        status_next = ST_HALTED;
                        state_next  = S_DONE;
                    end
                    else if (obstacle)
                    begin
                        status_next = ST_OBSTACLE;
                        state_next  = S_DONE;
                    end
                    else if (len == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        phase_next = PH_SEARCH;
                        idx_next   = start_reg;
                        state_next = (start_reg < len) ? S_READ : S_RDWT;
                        if (start_reg >= len)
                        begin
                            idx_next   = len - 1'b1;
                            start_next = len - 1'b1;
                            phase_next = PH_TARGET;
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_READ: begin cmd.op = OP_READ; state_next = S_RDWT; end
            S_RDWT: begin cmd.op = OP_READ; state_next = S_DIST; end
            S_DIST: begin cmd.op = OP_DIST; state_next = S_SQ; end
            S_SQ:   begin cmd.op = OP_SQUARE; state_next = S_SUM; end
            S_SUM:  begin cmd.op = OP_SUM; state_next = S_TEST; end
            S_TEST:
            begin
                unique case (phase_reg)
                    PH_SEARCH:
                    begin
                        if (stat.far_enough || idx_reg == len - 1'b1)
                        begin
                            // found, or fell back to the last point
                            start_next = idx_reg;
                            phase_next = PH_TARGET;
                            state_next = S_VINI;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                    PH_TARGET: state_next = S_VINI;
                    default:
                    begin
                        if (stat.in_goal)
                        begin
                            halted_next = 1'b1;
                            status_next = ST_HALTED;
                            dps_next    = 1'b0;
                        end
                        else
                        begin
                            status_next = ST_DRIVE;
                            dps_next    = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                endcase
            end
            S_VINI:
            begin
                cmd.op = OP_VEC_INI;
                cnt_next = '0;
                state_next = S_VIT;
            end
            S_VIT:
            begin
                cmd.op = OP_VEC_IT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'(CORDIC_STEPS - 1))
                    state_next = S_RINI;
            end
            S_RINI:
            begin
                cmd.op = OP_ROT_INI;
                cnt_next = '0;
                state_next = S_RIT;
            end
            S_RIT:
            begin
                cmd.op = OP_ROT_IT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'(CORDIC_STEPS - 1))
                begin
                    cnt_next = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.op = (cnt_reg == 6'd0) ? OP_MUL1 : (cnt_reg == 6'd1) ? OP_MUL2 : OP_DIV_INI;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd2)
                begin
                    cnt_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_IT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd35)
                    state_next = S_SPD;
            end
            S_SPD:
            begin
                cmd.op     = OP_SPEEDS;
                idx_next   = len - 1'b1;
                phase_next = PH_GOAL;
                state_next = S_READ;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_SEARCH;
            idx_reg    <= '0;
            start_reg  <= '0;
            cnt_reg    <= '0;
            halted_reg <= 1'b0;
            status_reg <= ST_DRIVE;
            dps_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            start_reg  <= start_next;
            cnt_reg    <= cnt_next;
            halted_reg <= halted_next;
            status_reg <= status_next;
            dps_reg    <= dps_next;
        end
    end

    assign done          = (state_reg == S_DONE);
    assign use_dp_speeds = dps_reg;
    assign status        = status_reg;
    assign target_index  = start_reg[9:0];

endmodule

// ===== hdl/pure_pursuit_steering.sv =====
// ----------------------------------------------------------------------------
// Pure pursuit steering
// Path store plus look-ahead search and CORDIC steering for a two-wheel robot.
// ----------------------------------------------------------------------------
// A load or an early stop passes from the accepting edge through the start register
// and the controller's idle and done states to the result register; a driving tick
// also runs the forward search (a store read, distance and test per point), 28 CORDIC
// steps, the multiply and divide-setup steps, 36 divide steps and the goal test.
// One item at a time; the next item is taken once the result beat has left.
// Reset clears control state, search start, halt; sets config defaults; path store is kept.
// ----------------------------------------------------------------------------
module pure_pursuit_steering
    import pps_pkg::*;
#(
    parameter int PATH_DEPTH = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // opcode, point_index, point_x_mm, point_y_mm,
                                    // pose_x_mm, pose_y_mm, pose_heading,
                                    // obstacle_distance_mm, zero fill
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // left_speed, right_speed, target_index, status, zero fill
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [10:0]  cfg_data
);

    localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int IW = $clog2(PATH_DEPTH + 1) > 11 ? $clog2(PATH_DEPTH + 1) : 11;

    logic [10:0] speed_reg, look_reg, goal_reg, len_reg;
    logic [9:0]  track_reg;

    // Configuration writes
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= 11'd100;
            look_reg  <= 11'd50;
            track_reg <= 10'd100;
            goal_reg  <= 11'd50;
            len_reg   <= 11'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SPEED: speed_reg <= cfg_data;
                REG_LOOK:  look_reg  <= cfg_data;
                REG_TRACK: track_reg <= cfg_data[9:0];
                REG_GOAL:  goal_reg  <= cfg_data;
                REG_LEN:   len_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input capture
    logic               busy_reg;
    logic               accept;
    logic signed [15:0] px_reg, py_reg, th_reg;
    logic               load_reg;
    logic               start_reg;
    logic               obst_reg;
    logic               done;
    logic               m_valid_reg;

    assign s_tready = !busy_reg && !m_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg   <= s_tdata[58:43];
            py_reg   <= s_tdata[74:59];
            th_reg   <= s_tdata[90:75];
            load_reg <= !s_tdata[0];
            obst_reg <= (s_tdata[106:91] < {5'b0, look_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= accept;
            if (accept)
                busy_reg <= 1'b1;
            else if (done)
                busy_reg <= 1'b0;
        end
    end

    logic wr_en;
    assign wr_en = accept && !s_tdata[0] && (32'(s_tdata[10:1]) < PATH_DEPTH);

    pps_cmd_t           cmd;
    pps_stat_t          stat;
    logic signed [15:0] dp_left, dp_right;
    logic               use_dp;
    logic [2:0]         status;
    logic [9:0]         tgt;

    pps_ctrl #(.PATH_DEPTH(PATH_DEPTH), .IW(IW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .is_load(load_reg),
        .obstacle(obst_reg), .path_length(len_reg), .stat(stat), .cmd(cmd),
        .done(done), .use_dp_speeds(use_dp), .status(status), .target_index(tgt)
    );

    pps_datapath #(.PATH_DEPTH(PATH_DEPTH), .AW(AW)) u_dp (
        .clk(clk), .cmd(cmd), .stat(stat),
        .wr_en(wr_en), .wr_addr(AW'(s_tdata[10:1])),
        .wr_x(s_tdata[26:11]), .wr_y(s_tdata[42:27]),
        .pose_x(px_reg), .pose_y(py_reg), .pose_th(th_reg),
        .forward_speed(speed_reg), .lookahead(look_reg), .track_width(track_reg),
        .goal_tolerance(goal_reg), .left_speed(dp_left), .right_speed(dp_right)
    );

    // Result register
    logic [47:0] m_data_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (done)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            m_data_reg <= {3'b0, status, tgt,
                           use_dp ? dp_right : 16'sd0,
                           use_dp ? dp_left : 16'sd0};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // No new item while one is in progress; done only with an item; a result follows done
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_tready) else $error("accept while busy");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg) else $error("done without item");
    a_valid_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> m_tvalid) else $error("result lost");

endmodule

// ===== bench/tb_pure_pursuit_steering.sv =====
// ----------------------------------------------------------------------------
// Pure pursuit steering testbench
// Loads random-walk and zigzag paths, drives control ticks near and off them across register
// settings and idle patterns, and checks every result beat against an
// in-bench steering predictor (look-ahead search, CORDIC angle and sine,
// rounded turn term, saturation, obstacle stop and sticky goal halt).
// ----------------------------------------------------------------------------
module tb_pure_pursuit_steering;
    import pps_pkg::*;

    localparam int  DEPTH     = 1024;
    localparam int  IN_W      = 112;
    localparam int  LIMIT     = 10000000;
    localparam bit  CMD_LOAD  = 1'b0;
    localparam bit  CMD_TICK  = 1'b1;

    typedef struct packed {
        logic [15:0]        obstacle;
        logic signed [15:0] heading;
        logic signed [15:0] pose_y;
        logic signed [15:0] pose_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_x;
        logic [9:0]         slot;
        logic               cmd;
    } item_t;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic [9:0]  target;
        logic [2:0]  status;
    } wheel_cmd_t;

    // Steering predictor and queue of pending wheel commands
    class steer_scoreboard;
        int unsigned speed, look, track, goal_tol, path_len;
        logic signed [15:0] path_x [DEPTH];
        logic signed [15:0] path_y [DEPTH];
        int unsigned search_idx;
        bit halted;
        wheel_cmd_t pending[$];
        int unsigned mismatches, beats;
        int unsigned ticks_driven, halts_seen, stops_seen, loads_seen;

        function new();
            speed = 100; look = 50; track = 100; goal_tol = 50; path_len = 0;
            search_idx = 0; halted = 0;
        endfunction

        function void set_reg(logic [2:0] idx, int unsigned val);
            case (idx)
                REG_SPEED: speed    = val & 11'h7FF;
                REG_LOOK:  look     = val & 11'h7FF;
                REG_TRACK: track    = val & 10'h3FF;
                REG_GOAL:  goal_tol = val & 11'h7FF;
                REG_LEN:   path_len = val & 11'h7FF;
                default: ;
            endcase
        endfunction

        function longint heading_to(longint dx, longint dy);
            longint x, y, z, t, nx, ny;
            x = dx * 16; y = dy * 16; z = 0;
            if (dx == 0 && dy == 0) return 0;
            if (x < 0) begin
                if (y >= 0) begin t = x; x = y; y = -t; z = HALF_PI_Q; end
                else begin t = x; x = -y; y = t; z = -HALF_PI_Q; end
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (y >= 0) begin
                    nx = x + (y >>> i); ny = y - (x >>> i); z += atan_q13(i);
                end
                else begin
                    nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_q13(i);
                end
                x = nx; y = ny;
            end
            return z;
        endfunction

        function longint sine14(longint a);
            longint x, y, z, nx, ny;
            x = INV_GAIN_Q14; y = 0; z = a;
            if (z > HALF_PI_Q) z = PI_Q - z;
            else if (z < -HALF_PI_Q) z = -PI_Q - z;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_q13(i);
                end
                else begin
                    nx = x + (y >>> i); ny = y - (x >>> i); z += atan_q13(i);
                end
                x = nx; y = ny;
            end
            if (y > 16384) y = 16384;
            if (y < -16384) y = -16384;
            return y;
        endfunction

        function longint clip16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        // Work out the wheel command for one accepted beat
        function void note_input(item_t it);
            wheel_cmd_t e;
            longint lft, rgt, px, py, dx, dy, alpha, s, num, den, mag, delta;
            int unsigned len, tgt;
            lft = 0; rgt = 0;
            if (it.cmd == CMD_LOAD) begin
                path_x[it.slot] = it.point_x;
                path_y[it.slot] = it.point_y;
                e.status = ST_LOADED;
                loads_seen++;
            end
            else if (halted) begin
                e.status = ST_HALTED;
            end
            else if (it.obstacle < look) begin
                e.status = ST_OBSTACLE;
                stops_seen++;
            end
            else if (path_len == 0) begin
                e.status = ST_EMPTY;
            end
            else begin
                px = it.pose_x; py = it.pose_y;
                len = (path_len > DEPTH) ? DEPTH : path_len;
                tgt = len - 1;
                for (int unsigned i = search_idx; i < len; i++) begin
                    dx = longint'(path_x[i]) - px; dy = longint'(path_y[i]) - py;
                    if (dx * dx + dy * dy >= longint'(look) * look) begin
                        tgt = i;
                        break;
                    end
                end
                search_idx = tgt;
                dx = longint'(path_x[tgt]) - px; dy = longint'(path_y[tgt]) - py;
                alpha = heading_to(dx, dy) - longint'(it.heading);
                repeat (2)
                begin
                    if (alpha > PI_Q) alpha -= TWO_PI_Q;
                    if (alpha < -PI_Q) alpha += TWO_PI_Q;
                end
                s = sine14(alpha);
                num = longint'(track) * longint'(speed) * s;
                den = longint'(look == 0 ? 1 : look) * 16384;
                mag = (num < 0) ? -num : num;
                mag = (mag + den / 2) / den;
                delta = (num < 0) ? -mag : mag;
                lft = clip16(longint'(speed) - delta);
                rgt = clip16(longint'(speed) + delta);
                e.status = ST_DRIVE;
                dx = longint'(path_x[len-1]) - px; dy = longint'(path_y[len-1]) - py;
                if (dx * dx + dy * dy < longint'(goal_tol) * goal_tol) begin
                    halted = 1; lft = 0; rgt = 0;
                    e.status = ST_HALTED;
                    halts_seen++;
                end
                ticks_driven++;
            end
            e.left = lft[15:0];
            e.right = rgt[15:0];
            e.target = search_idx[9:0];
            pending.push_back(e);
        endfunction

        // Compare one result beat with the oldest pending command
        function void check_result(logic [47:0] d);
            wheel_cmd_t e;
            beats++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", d);
                return;
            end
            e = pending.pop_front();
            if (d[15:0] !== e.left || d[31:16] !== e.right || d[41:32] !== e.target ||
                d[44:42] !== e.status || d[47:45] !== 3'b0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: exp L=%0d R=%0d tgt=%0d st=%0d, got L=%0d R=%0d tgt=%0d st=%0d",
                             beats, $signed(e.left), $signed(e.right), e.target, e.status,
                             $signed(d[15:0]), $signed(d[31:16]), d[41:32], d[44:42]);
            end
        endfunction
    endclass

    logic            clk = 0;
    logic            rst_n = 0;
    logic            s_tvalid = 0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 0;
    logic [47:0]     m_tdata;
    logic            cfg_valid = 0;
    logic            cfg_ready;
    logic [2:0]      cfg_index = '0;
    logic [10:0]     cfg_data = '0;

    steer_scoreboard sb = new();
    int unsigned     cycles = 0;
    int unsigned     idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
    bit              written [DEPTH];

    pure_pursuit_steering dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: stall at random in the receiver idle modes, check beats at the rising edge
    always @(negedge clk)
        m_tready = (idle_mode >= 2) ? (idle_mode == 2 ? $urandom_range(99) >= 84
                                                      : $urandom_range(99) >= 27)
                                    : 1'b1;

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);

    task automatic send(input item_t it);
        int unsigned p;
        p = (idle_mode == 1) ? 84 : (idle_mode == 3 ? 27 : 0);
        while ($urandom_range(99) < p) @(negedge clk);
        s_tvalid = 1;
        s_tdata  = {5'b0, it};
        do @(posedge clk); while (!s_tready);
        sb.note_input(it);
        if (it.cmd == CMD_LOAD) written[it.slot] = 1;
        @(negedge clk);
        s_tvalid = 0;
    endtask

    task automatic load_point(input int unsigned slot, input logic [15:0] x, input logic [15:0] y);
        item_t it;
        it = '0;
        it.cmd = CMD_LOAD; it.slot = slot; it.point_x = x; it.point_y = y;
        it.pose_x = $urandom; it.pose_y = $urandom; it.heading = $urandom;
        it.obstacle = $urandom;
        send(it);
    endtask

    task automatic tick(input logic [15:0] x, input logic [15:0] y,
                        input logic [15:0] hd, input logic [15:0] obs);
        item_t it;
        it = '0;
        it.cmd = CMD_TICK; it.slot = $urandom; it.point_x = $urandom; it.point_y = $urandom;
        it.pose_x = x; it.pose_y = y; it.heading = hd; it.obstacle = obs;
        send(it);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_valid = 1; cfg_index = idx; cfg_data = 11'(val);
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    // Lay down a random-walk path in slots 0..n-1
    task automatic lay_path(input int unsigned n);
        int x, y;
        x = $signed($urandom_range(40000)) - 20000;
        y = $signed($urandom_range(40000)) - 20000;
        for (int unsigned i = 0; i < n; i++)
        begin
            load_point(i, x, y);
            x += $signed($urandom_range(1600)) - 800;
            y += $signed($urandom_range(1600)) - 800;
        end
    endtask

    // Alternate two far corners so every pose finds a far point within two slots
    task automatic lay_zigzag(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            load_point(i, i[0] ? 16'sd5000 : -16'sd5000, i[0] ? 16'sd5000 : -16'sd5000);
    endtask

    // Random mix of ticks around the path and stray loads
    task automatic wander(input int unsigned n);
        int unsigned len, k, r, span;
        int ox, oy;
        logic [15:0] obs, hd;
        len = (sb.path_len > DEPTH) ? DEPTH : sb.path_len;
        for (int unsigned j = 0; j < n; j++)
        begin
            r = $urandom_range(99);
            if (r < 15 || len == 0) begin
                k = (r < 5) ? $urandom_range(DEPTH - 1) : (len ? $urandom_range(len - 1) : 0);
                if (r < 8 || !written[k]) load_point(k, $urandom, $urandom);
                else load_point(k, sb.path_x[k] + $signed($urandom_range(200)) - 100,
                                sb.path_y[k] + $signed($urandom_range(200)) - 100);
            end
            else begin
                k = sb.search_idx + $urandom_range(3);
                if (k >= len) k = len - 1;
                if (!written[k]) k = sb.search_idx;
                span = 2 * sb.look + 50;
                ox = $signed($urandom_range(2 * span)) - int'(span);
                oy = $signed($urandom_range(2 * span)) - int'(span);
                hd = (r < 25) ? 16'($urandom) : 16'($signed($urandom_range(51472)) - 25736);
                obs = (r < 30) ? 16'($urandom_range(sb.look)) : 16'($urandom);
                if (obs < sb.look && r >= 30) obs = 16'hFFFF;
                if (r < 20) tick($urandom, $urandom, hd, obs);
                else tick(sb.path_x[k] + ox, sb.path_y[k] + oy, hd, obs);
            end
        end
    endtask

    task automatic phase(input int unsigned mode, input int unsigned spd, input int unsigned lk,
                         input int unsigned trk, input int unsigned tol, input int unsigned npts,
                         input int unsigned len, input int unsigned n);
        idle_mode = mode;
        lay_path(npts);
        drain();
        write_reg(REG_SPEED, spd);
        write_reg(REG_LOOK, lk);
        write_reg(REG_TRACK, trk);
        write_reg(REG_GOAL, tol);
        write_reg(REG_LEN, len);
        wander(n);
        drain();
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: empty path, obstacle, extreme loads, coincident target
        tick(16'h8000, 16'h7FFF, 16'sd25736, 16'hFFFF);
        tick(0, 0, -16'sd25736, 16'd49);
        tick(0, 0, 0, 16'd0);
        load_point(0, 16'h8000, 16'h7FFF);
        load_point(DEPTH - 1, 16'h7FFF, 16'h8000);
        load_point(1, 16'h7FFF, 16'h7FFF);
        load_point(2, 16'h8000, 16'h8000);
        load_point(3, 0, 0);
        drain();
        write_reg(REG_GOAL, 0);
        write_reg(REG_LOOK, 2000);
        write_reg(REG_LEN, 4);
        tick(0, 0, 0, 16'hFFFF);
        tick(0, 0, 16'sd25736, 16'd2000);
        tick(16'h8000, 16'h8000, -16'sd25736, 16'hFFFF);
        tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        tick(0, 0, 16'h8000, 16'd1999);
        drain();

        phase(0, 100, 50, 100, 0, 10, 10, 30);
        phase(1, 2000, 1, 1000, 0, 0, 10, 35);
        phase(2, 0, 2000, 1, 0, 0, 3, 25);
        phase(3, 777, 0, 500, 0, 20, 20, 30);
        idle_mode = 0;
        lay_zigzag(56);
        phase(0, 1500, 300, 400, 0, 0, 2047, 12);
        phase(3, 1200, 150, 700, 0, 0, DEPTH, 10);
        phase(2, 300, 200, 200, 2000, 12, 12, 25);
        phase(1, 50, 60, 90, 1000, 0, 12, 20);

        idle_mode = 0;
        drain();
        repeat (200) @(negedge clk);
        $display("Covered %0d loads, %0d steering ticks, %0d obstacle stops, %0d goal halts;",
                 sb.loads_seen, sb.ticks_driven, sb.stops_seen, sb.halts_seen);
        $display("%0d result beats checked, %0d mismatches, %0d cycles.",
                 sb.beats, sb.mismatches, cycles);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pps_pkg.sv
hdl/pps_datapath.sv
hdl/pps_ctrl.sv
hdl/pure_pursuit_steering.sv
bench/tb_pure_pursuit_steering.sv
